// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files of the window entropy block
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define SWCE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SWCE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/swce_pkg.sv =====
// shared constants, types and lookup tables of the window entropy block
// no dependencies; used by the interfaces, the divider and the top level
package swce_pkg;

    // sizing
    localparam int MAX_WINDOW   = 64;
    localparam int ALPHABET     = 20;
    localparam int FRAC_BITS    = 12;
    localparam int WIN_W        = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W        = $clog2(MAX_WINDOW);
    localparam int CNT_W        = WIN_W;
    localparam int CLS_W        = $clog2(ALPHABET + 1);
    localparam int LG_W         = $clog2($clog2(MAX_WINDOW) + 1) + FRAC_BITS;
    localparam int CLOG_W       = CNT_W + LG_W;
    localparam int QUO_W        = LG_W;
    localparam int STEP_W       = $clog2(QUO_W);

    // field widths
    localparam int RESIDUE_W    = 8;
    localparam int ENT_W        = 15;
    localparam int POS_W        = 16;
    localparam int CUT_W        = 15;
    localparam int WLEN_FIELD_W = 7;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;

    localparam logic [ENT_W-1:0] ENT_MAX    = ENT_W'(32767);
    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam logic [CLS_W-1:0] CLS_OTHER  = CLS_W'(ALPHABET);

    // register reset values
    localparam logic [WIN_W-1:0] WLEN_RESET = WIN_W'(12);
    localparam logic [CUT_W-1:0] TRIG_RESET = CUT_W'(9011);
    localparam logic [CUT_W-1:0] EXT_RESET  = CUT_W'(10240);

    // character codes for case folding
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // amino acid letters, class k sits at byte ALPHABET-1-k
    localparam logic [ALPHABET*8-1:0] AMINO_LETTERS = "ACDEFGHIKLMNPQRSTVWY";

    // register map, index is paddr[3:2]
    typedef enum logic [APB_ADDR_W-3:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_TRIGGER_CUT   = 2'd1,
        REG_EXTENSION_CUT = 2'd2
    } reg_index_t;

    // per-residue sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_ADD,
        S_PREP,
        S_DIV,
        S_DONE
    } swce_state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef logic [MAX_WINDOW:0][CLOG_W-1:0] clog_table_t;

    // residue character to class code, non amino letters map to CLS_OTHER
    function automatic logic [CLS_W-1:0] class_of(input logic [RESIDUE_W-1:0] ch);
        logic [7:0]       up;
        logic [CLS_W-1:0] cls;
        int               k;
        up  = ch;
        cls = CLS_OTHER;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            up = ch - CASE_OFFSET;
        end
        for (k = 0; k < ALPHABET; k++)
        begin
            if (AMINO_LETTERS[(ALPHABET-1-k)*8 +: 8] == up)
            begin
                cls = CLS_W'(k);
            end
        end
        return cls;
    endfunction

    // log2 in q.12 by repeated squaring of the mantissa, elaboration only
    function automatic logic [LG_W-1:0] lg_q12(input int unsigned n);
        int unsigned k;
        int unsigned j;
        int unsigned b;
        logic [63:0] m;
        logic [19:0] frac;
        logic [31:0] v;
        k    = 0;
        frac = '0;
        if (n == 0)
        begin
            return '0;
        end
        for (j = 0; j < 31; j++)
        begin
            if ((n >> (j + 1)) != 0)
            begin
                k = j + 1;
            end
        end
        m = 64'(n) << (31 - k);
        for (b = 0; b < 20; b++)
        begin
            m    = (m * m) >> 31;
            frac = {frac[18:0], 1'b0};
            if (m >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        v = ((32'(k) << 20) | 32'(frac)) + 32'd128;
        return LG_W'(v >> 8);
    endfunction

    // c * log2(c) for every count the window can hold
    function automatic clog_table_t build_clog_table();
        clog_table_t t;
        int unsigned n;
        t = '0;
        for (n = 1; n <= MAX_WINDOW; n++)
        begin
            t[n] = CLOG_W'(n * 32'(lg_q12(n)));
        end
        return t;
    endfunction

    localparam clog_table_t CLOG_TABLE = build_clog_table();

endpackage

// ===== hw/rtl/swce_if.sv =====
// stream interfaces for residue input and entropy results
// depends on swce_pkg for field widths
interface swce_in_if import swce_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [RESIDUE_W-1:0] residue;
    logic                 sequence_start;

    modport source (output valid, output residue, output sequence_start, input ready);
    modport sink   (input valid, input residue, input sequence_start, output ready);
endinterface

interface swce_out_if import swce_pkg::*;;
    logic             valid;
    logic             ready;
    logic             window_full;
    logic [ENT_W-1:0] entropy_bits;
    logic [POS_W-1:0] centre_position;
    logic             is_low;
    logic             is_high;

    modport source (output valid, output window_full, output entropy_bits,
                    output centre_position, output is_low, output is_high, input ready);
    modport sink   (input valid, input window_full, input entropy_bits,
                    input centre_position, input is_low, input is_high, output ready);
endinterface

// ===== hw/rtl/swce_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module swce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/swce_div.sv =====
// restoring divider, one quotient bit per cycle, for the entropy quotient
// depends on swce_pkg for widths and the status struct
module swce_div import swce_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CLOG_W-1:0] numer,
    input  logic [CNT_W-1:0]  denom,
    output logic [QUO_W-1:0]  quotient,
    output div_status_t       status
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CLOG_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [CLOG_W-1:0] shifted;
    logic              fits;

    // trial subtract of the divisor aligned to the current quotient bit
    assign shifted = CLOG_W'(den_reg) << step_reg;
    assign fits    = rem_reg >= shifted;

    // step control and remainder update
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(QUO_W - 1);
            rem_next  = numer;
            den_next  = denom;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - shifted;
                quo_next = quo_reg | (QUO_W'(1) << step_reg);
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/sliding_window_composition_entropy.sv =====
// top level: sliding window composition entropy of a protein residue stream
// depends on swce_pkg, swce_if, swce_ram, swce_div and assert_macros.svh
//
// Takes one residue character per transaction and returns one result per
// residue: once the window holds window_length residues, the Shannon entropy
// in bits (q.12) of the counts of the 20 standard amino acids in the window,
// the centre position and the low/high threshold flags; before that all
// result fields are zero. The block accepts a residue only while its
// sequencer is idle. For a residue whose window is full and holds at least
// one counted residue, the path from acceptance to the result register is:
// the oldest entry of the 64-entry window ram is read at acceptance, then the
// evict state drops it from the counts, the add state counts the new residue,
// the prep state sets up the quotient, the restoring divider yields 15
// quotient bits, one per cycle, and raises done, and the done state loads the
// result. Other residues skip the divider. The next residue is taken in the
// cycle after the result loads; no residue is taken while one is in flight.
// A result waiting to be taken does not block the next residue until that
// residue is ready to load its own result.
// Writing window_length clears the window and counts; the window ram needs no
// clearing pass. Registers: window_length at 0x0, trigger_cut at 0x4,
// extension_cut at 0x8.
`include "assert_macros.svh"

module sliding_window_composition_entropy import swce_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    swce_in_if.sink               residue_ch,
    swce_out_if.source            result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    swce_state_t       state_reg, state_next;

    // configuration
    logic [WIN_W-1:0]  win_len_reg, win_len_next;
    logic [CUT_W-1:0]  trig_reg, trig_next;
    logic [CUT_W-1:0]  ext_reg, ext_next;

    // window state
    logic [CNT_W-1:0]  cnt_reg [ALPHABET];
    logic [CNT_W-1:0]  cnt_next [ALPHABET];
    logic [CNT_W-1:0]  counted_total_reg, counted_total_next;
    logic [CLOG_W-1:0] clog_sum_reg, clog_sum_next;
    logic [WIN_W-1:0]  fill_level_reg, fill_level_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [POS_W-1:0]  position_reg, position_next;

    // per-transaction working registers
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic              evict_reg, evict_next;
    logic              full_reg, full_next;
    logic              nonzero_reg, nonzero_next;
    logic [POS_W-1:0]  idx_reg, idx_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_full_reg, out_full_next;
    logic [ENT_W-1:0]  out_ent_reg, out_ent_next;
    logic [POS_W-1:0]  out_centre_reg, out_centre_next;
    logic              out_low_reg, out_low_next;
    logic              out_high_reg, out_high_next;

    // control decodes
    logic              in_ready;
    logic              accept;
    logic              ram_we;
    logic              div_start;
    logic              out_load;
    logic              prep_divide;

    // configuration write decode
    logic              cfg_write;
    reg_index_t        cfg_index;
    logic [WLEN_FIELD_W-1:0] wlen_field;
    logic [WIN_W-1:0]  wlen_clamped;

    // datapath helpers
    logic [WIN_W:0]    oldest_sum;
    logic [WIN_W:0]    oldest_wrap;
    logic [PTR_W-1:0]  oldest_addr;
    logic [CLS_W-1:0]  ram_rdata;
    logic [CLS_W-1:0]  sel_cls;
    logic              sel_counted;
    logic [CNT_W-1:0]  cnt_sel;
    logic [CLOG_W-1:0] clog_cur;
    logic [CLOG_W-1:0] clog_dn;
    logic [CLOG_W-1:0] clog_up;
    logic [CLOG_W-1:0] clog_top;
    logic [CLOG_W-1:0] div_numer;
    logic [QUO_W-1:0]  quotient;
    div_status_t       div_stat;
    logic [31:0]       quo_wide;
    logic [ENT_W-1:0]  ent_val;
    logic [CUT_W-1:0]  eff_cut;
    logic [POS_W-1:0]  centre_val;
    logic              window_is_full;
    logic [WIN_W-1:0]  fill_base;
    logic              evict_now;

    // apb access
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign cfg_index  = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wlen_field = pwdata[WLEN_FIELD_W-1:0];

    // window length of zero means one, anything past the store depth is clamped
    always_comb
    begin
        if (wlen_field == '0)
        begin
            wlen_clamped = WIN_W'(1);
        end
        else if (32'(wlen_field) > 32'(MAX_WINDOW))
        begin
            wlen_clamped = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            wlen_clamped = WIN_W'(wlen_field);
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_index)
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(win_len_reg);
            REG_TRIGGER_CUT:   prdata = APB_DATA_W'(trig_reg);
            REG_EXTENSION_CUT: prdata = APB_DATA_W'(ext_reg);
            default:           prdata = '0;
        endcase
    end

    // oldest entry of the ring, wr_ptr - window_length modulo the store depth
    assign oldest_sum  = (WIN_W+1)'(wr_ptr_reg) + (WIN_W+1)'(MAX_WINDOW)
                         - (WIN_W+1)'(win_len_reg);
    assign oldest_wrap = (oldest_sum >= (WIN_W+1)'(MAX_WINDOW))
                         ? oldest_sum - (WIN_W+1)'(MAX_WINDOW) : oldest_sum;
    assign oldest_addr = PTR_W'(oldest_wrap);

    // sequence start empties the window before this residue goes in
    assign fill_base = residue_ch.sequence_start ? '0 : fill_level_reg;
    assign evict_now = fill_base >= win_len_reg;

    swce_ram #(
        .WIDTH (CLS_W),
        .DEPTH (MAX_WINDOW)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (cls_reg),
        .re    (accept),
        .raddr (oldest_addr),
        .rdata (ram_rdata)
    );

    // one count read port: evicted class first, then the new class
    assign sel_cls     = (state_reg == S_EVICT) ? ram_rdata : cls_reg;
    assign sel_counted = sel_cls < CLS_OTHER;
    assign cnt_sel     = sel_counted ? cnt_reg[sel_cls] : '0;
    assign clog_cur    = CLOG_TABLE[cnt_sel];
    assign clog_dn     = CLOG_TABLE[cnt_sel - 1'b1];
    assign clog_up     = CLOG_TABLE[cnt_sel + 1'b1];

    // numerator of the entropy quotient, total*lg(total) - clog_sum
    assign clog_top       = CLOG_TABLE[counted_total_reg];
    assign div_numer      = (clog_top >= clog_sum_reg) ? clog_top - clog_sum_reg : '0;
    assign window_is_full = fill_level_reg >= win_len_reg;
    assign prep_divide    = window_is_full && (counted_total_reg != '0);

    swce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (counted_total_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    // result fields
    assign quo_wide   = 32'(quotient);
    assign ent_val    = (full_reg && nonzero_reg)
                        ? ((quo_wide > 32'(ENT_MAX)) ? ENT_MAX : quo_wide[ENT_W-1:0])
                        : '0;
    assign eff_cut    = (ext_reg < trig_reg) ? trig_reg : ext_reg;
    assign centre_val = idx_reg - POS_W'(win_len_reg >> 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (residue_ch.valid)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT: state_next = S_ADD;
            S_ADD:   state_next = S_PREP;
            S_PREP:  state_next = prep_divide ? S_DIV : S_DONE;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready  = 1'b1;
            S_ADD:   ram_we    = 1'b1;
            S_PREP:  div_start = prep_divide;
            S_DONE:  out_load  = !out_valid_reg || result_ch.ready;
            S_EVICT, S_DIV:
            begin
                in_ready = 1'b0;
            end
            default: in_ready = 1'b0;
        endcase
    end

    assign accept           = residue_ch.valid && in_ready;
    assign residue_ch.ready = in_ready;

    // window, count and result updates
    always_comb
    begin
        int k;
        win_len_next       = win_len_reg;
        trig_next          = trig_reg;
        ext_next           = ext_reg;
        cnt_next           = cnt_reg;
        counted_total_next = counted_total_reg;
        clog_sum_next      = clog_sum_reg;
        fill_level_next    = fill_level_reg;
        wr_ptr_next        = wr_ptr_reg;
        position_next      = position_reg;
        cls_next           = cls_reg;
        evict_next         = evict_reg;
        full_next          = full_reg;
        nonzero_next       = nonzero_reg;
        idx_next           = idx_reg;
        out_valid_next     = out_valid_reg && !result_ch.ready;
        out_full_next      = out_full_reg;
        out_ent_next       = out_ent_reg;
        out_centre_next    = out_centre_reg;
        out_low_next       = out_low_reg;
        out_high_next      = out_high_reg;

        // take the residue, restart the sequence if asked
        if (accept)
        begin
            cls_next        = class_of(residue_ch.residue);
            evict_next      = evict_now;
            fill_level_next = evict_now ? fill_base : fill_base + 1'b1;
            if (residue_ch.sequence_start)
            begin
                for (k = 0; k < ALPHABET; k++)
                begin
                    cnt_next[k] = '0;
                end
                counted_total_next = '0;
                clog_sum_next      = '0;
                wr_ptr_next        = '0;
                position_next      = '0;
            end
        end

        // drop the residue leaving the window
        if (state_reg == S_EVICT && evict_reg && sel_counted && cnt_sel != '0)
        begin
            for (k = 0; k < ALPHABET; k++)
            begin
                if (sel_cls == CLS_W'(k))
                begin
                    cnt_next[k] = cnt_sel - 1'b1;
                end
            end
            counted_total_next = counted_total_reg - 1'b1;
            clog_sum_next      = clog_sum_reg - clog_cur + clog_dn;
        end

        // store and count the new residue, advance position
        if (state_reg == S_ADD)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == MAX_WINDOW - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (sel_counted)
            begin
                for (k = 0; k < ALPHABET; k++)
                begin
                    if (sel_cls == CLS_W'(k))
                    begin
                        cnt_next[k] = cnt_sel + 1'b1;
                    end
                end
                counted_total_next = counted_total_reg + 1'b1;
                clog_sum_next      = clog_sum_reg - clog_cur + clog_up;
            end
            idx_next = position_reg;
            if (position_reg != POS_MAX)
            begin
                position_next = position_reg + 1'b1;
            end
        end

        // latch result qualifiers before the divide
        if (state_reg == S_PREP)
        begin
            full_next    = window_is_full;
            nonzero_next = counted_total_reg != '0;
        end

        // result register load
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_full_next   = full_reg;
            out_ent_next    = ent_val;
            out_centre_next = full_reg ? centre_val : '0;
            out_low_next    = full_reg && (ent_val <= trig_reg);
            out_high_next   = full_reg && (ent_val > eff_cut);
        end

        // configuration writes, a new window length restarts filling
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:
                begin
                    win_len_next = wlen_clamped;
                    for (k = 0; k < ALPHABET; k++)
                    begin
                        cnt_next[k] = '0;
                    end
                    counted_total_next = '0;
                    clog_sum_next      = '0;
                    fill_level_next    = '0;
                    wr_ptr_next        = '0;
                end
                REG_TRIGGER_CUT:   trig_next = pwdata[CUT_W-1:0];
                REG_EXTENSION_CUT: ext_next  = pwdata[CUT_W-1:0];
                default:           trig_next = trig_reg;
            endcase
        end
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            win_len_reg       <= WLEN_RESET;
            trig_reg          <= TRIG_RESET;
            ext_reg           <= EXT_RESET;
            cnt_reg           <= '{default: '0};
            counted_total_reg <= '0;
            clog_sum_reg      <= '0;
            fill_level_reg    <= '0;
            wr_ptr_reg        <= '0;
            position_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            win_len_reg       <= win_len_next;
            trig_reg          <= trig_next;
            ext_reg           <= ext_next;
            cnt_reg           <= cnt_next;
            counted_total_reg <= counted_total_next;
            clog_sum_reg      <= clog_sum_next;
            fill_level_reg    <= fill_level_next;
            wr_ptr_reg        <= wr_ptr_next;
            position_reg      <= position_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cls_reg        <= cls_next;
        evict_reg      <= evict_next;
        full_reg       <= full_next;
        nonzero_reg    <= nonzero_next;
        idx_reg        <= idx_next;
        out_full_reg   <= out_full_next;
        out_ent_reg    <= out_ent_next;
        out_centre_reg <= out_centre_next;
        out_low_reg    <= out_low_next;
        out_high_reg   <= out_high_next;
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.window_full     = out_full_reg;
    assign result_ch.entropy_bits    = out_ent_reg;
    assign result_ch.centre_position = out_centre_reg;
    assign result_ch.is_low          = out_low_reg;
    assign result_ch.is_high         = out_high_reg;

    // checks on window bookkeeping and sequencing
    `SWCE_ASSERT_ALWAYS(a_fill_within_window, fill_level_reg <= win_len_reg,
        "fill level past window length")
    `SWCE_ASSERT_ALWAYS(a_total_within_fill, counted_total_reg <= fill_level_reg,
        "counted total past fill level")
    `SWCE_ASSERT_NEXT(a_accept_reads_oldest, accept, state_reg == S_EVICT,
        "accepted residue did not start eviction")
    `SWCE_ASSERT_IMPLY(a_div_done_while_waiting, div_stat.done, state_reg == S_DIV,
        "divider finished outside wait state")
    `SWCE_ASSERT_IMPLY(a_short_window_zero, out_valid_reg && !out_full_reg,
        out_ent_reg == '0 && !out_low_reg && !out_high_reg,
        "result fields set before window full")

endmodule
